// ----- hw/rtl/mva_pkg.sv -----
package mva_pkg;

    // Voice pool and stamp sizes
    localparam int MAX_VOICES = 16;
    localparam int STAMP_BITS = 32;
    localparam int VIDX_W     = $clog2(MAX_VOICES);
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);
    localparam int CHAN_W     = 4;
    localparam int NOTE_W     = 7;
    localparam int CFG_W      = 5;

    // Request type codes
    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LISTEN_CHANNEL = 1'b0;
    localparam logic CFG_VOICES_IN_USE  = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] velocity;
    } req_t;

    typedef struct packed {
        logic                  voice_valid;
        logic [VIDX_W-1:0]     voice_index;
        logic                  stolen;
        logic                  start_trigger;
        logic                  end_trigger;
        logic [NOTE_W-1:0]     note_out;
        logic [NOTE_W-1:0]     velocity_out;
        logic [CNT_W-1:0]      active_voices;
        logic [MAX_VOICES-1:0] cleared_mask;
    } rsp_t;

    // Status from the shared subtract/compare unit
    typedef struct packed {
        logic less;   // a < b, unsigned
        logic aged;   // (a - b) mod 2^STAMP_BITS > 1
    } cmp_res_t;

    // Count set bits of a voice vector
    function automatic logic [CNT_W-1:0] count_ones(input logic [MAX_VOICES-1:0] vec);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            sum = sum + CNT_W'(vec[i]);
        end
        return sum;
    endfunction

endpackage

// ----- hw/rtl/mva_cmp_unit.sv -----
module mva_cmp_unit (
    input  logic [mva_pkg::STAMP_BITS-1:0] a,
    input  logic [mva_pkg::STAMP_BITS-1:0] b,
    output mva_pkg::cmp_res_t              res
);

    logic [mva_pkg::STAMP_BITS:0] diff;

    // One subtractor serves both the stamp order and the trigger age
    assign diff     = {1'b0, a} - {1'b0, b};
    assign res.less = diff[mva_pkg::STAMP_BITS];
    assign res.aged = |diff[mva_pkg::STAMP_BITS-1:1];

endmodule

// ----- hw/rtl/midi_voice_allocator_unit.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    mva_pkg::req_t
// rsp      out        rsp_valid/rsp_ready    mva_pkg::rsp_t
// cfg      in         cfg_we                 cfg_idx, cfg_wdata
//
// A note-on scans the voices in use, twice over when it has to steal.
// A note-off stops at the first match, a tick scans all MAX_VOICES, anything ignored skips the scan.
// The scan reads one voice per cycle through the shared subtract/compare unit.
// req_ready is low from acceptance until the result is loaded.
// A stalled result holds the block in its finish state until rsp is taken.
// Reset clears every voice, the frame counter and the count at once.
module midi_voice_allocator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  mva_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output mva_pkg::rsp_t                rsp,
    input  logic                         cfg_we,
    input  logic                         cfg_idx,
    input  logic [mva_pkg::CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_ON,
        OP_OFF,
        OP_TICK,
        OP_NONE
    } op_t;

    localparam int MV = mva_pkg::MAX_VOICES;
    localparam int SB = mva_pkg::STAMP_BITS;
    localparam int VW = mva_pkg::VIDX_W;
    localparam int CW = mva_pkg::CNT_W;

    // Voice store
    logic [MV-1:0]                 active_reg;
    logic [MV-1:0]                 start_reg;
    logic [MV-1:0]                 end_reg;
    logic [mva_pkg::NOTE_W-1:0]    note_reg  [MV];
    logic [SB-1:0]                 stamp_reg [MV];
    logic [SB-1:0]                 frame_reg;
    logic [CW-1:0]                 count_reg;

    // Configuration
    logic [mva_pkg::CHAN_W-1:0]    listen_reg;
    logic [mva_pkg::CFG_W-1:0]     voices_reg;

    // Sequencer
    state_t                        state_reg;
    op_t                           op_reg;
    mva_pkg::req_t                 req_reg;
    logic [VW-1:0]                 scan_reg;
    logic                          pass_reg;
    logic                          found_reg;
    logic [VW-1:0]                 best_idx_reg;
    logic [SB-1:0]                 best_stamp_reg;
    logic [MV-1:0]                 mask_reg;
    logic                          rsp_valid_reg;
    mva_pkg::rsp_t                 rsp_reg;

    logic                          accept;
    logic                          fin_fire;
    logic [VW-1:0]                 eff_m1;
    logic                          scan_last;
    logic                          steal_wrap;
    logic                          active_rd;
    logic [mva_pkg::NOTE_W-1:0]    note_rd;
    logic [SB-1:0]                 stamp_rd;
    logic [SB-1:0]                 op_a;
    logic [SB-1:0]                 op_b;
    mva_pkg::cmp_res_t             cmp;
    logic                          on_take;
    logic                          off_hit;
    logic                          tick_clr;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 cfg_eff;
    logic [MV-1:0]                 keep_mask;
    op_t                           op_dec;
    mva_pkg::rsp_t                 rsp_next;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign fin_fire  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    // Clamp the voice count to 1..MAX_VOICES; keep its last index
    always_comb
    begin
        if (voices_reg == '0)
            eff_m1 = '0;
        else if (voices_reg > mva_pkg::CFG_W'(MV))
            eff_m1 = VW'(MV - 1);
        else
            eff_m1 = VW'(voices_reg - 1'b1);
    end

    assign scan_last = (op_reg == OP_TICK) ? (scan_reg == VW'(MV - 1)) : (scan_reg == eff_m1);

    // Read the voice under the scan pointer
    assign active_rd = active_reg[scan_reg];
    assign note_rd   = note_reg[scan_reg];
    assign stamp_rd  = stamp_reg[scan_reg];

    // Route operands to the shared unit
    assign op_a = (op_reg == OP_TICK) ? frame_reg : stamp_rd;
    assign op_b = (op_reg == OP_TICK) ? stamp_rd  : best_stamp_reg;

    mva_cmp_unit u_cmp (
        .a   (op_a),
        .b   (op_b),
        .res (cmp)
    );

    assign on_take  = (state_reg == S_SCAN) && (op_reg == OP_ON)
                      && (pass_reg || !active_rd) && (!found_reg || cmp.less);
    assign off_hit  = (state_reg == S_SCAN) && (op_reg == OP_OFF)
                      && active_rd && (note_rd == req_reg.note);
    assign tick_clr = (state_reg == S_SCAN) && (op_reg == OP_TICK)
                      && cmp.aged && (start_reg[scan_reg] || end_reg[scan_reg]);

    // No free voice after the first pass: go round again and steal the oldest
    assign steal_wrap = (state_reg == S_SCAN) && (op_reg == OP_ON) && scan_last
                        && !pass_reg && !found_reg && !on_take;

    // Decode the incoming request
    always_comb
    begin
        if (req.req_type == mva_pkg::REQ_NOTE_ON && req.channel == listen_reg)
            op_dec = OP_ON;
        else if (req.req_type == mva_pkg::REQ_NOTE_OFF && req.channel == listen_reg)
            op_dec = OP_OFF;
        else if (req.req_type == mva_pkg::REQ_TICK)
            op_dec = OP_TICK;
        else
            op_dec = OP_NONE;
    end

    // Count after this request
    always_comb
    begin
        count_next = count_reg;
        if (op_reg == OP_ON && !pass_reg)
            count_next = count_reg + 1'b1;
        else if (op_reg == OP_OFF && found_reg && count_reg != '0)
            count_next = count_reg - 1'b1;
    end

    // Assemble the result
    always_comb
    begin
        rsp_next               = '0;
        rsp_next.active_voices = count_next;
        unique case (op_reg)
            OP_ON:
            begin
                rsp_next.voice_valid   = 1'b1;
                rsp_next.voice_index   = best_idx_reg;
                rsp_next.stolen        = pass_reg;
                rsp_next.start_trigger = 1'b1;
                rsp_next.note_out      = req_reg.note;
                rsp_next.velocity_out  = req_reg.velocity;
            end
            OP_OFF:
            begin
                rsp_next.voice_valid = found_reg;
                rsp_next.voice_index = found_reg ? best_idx_reg : '0;
                rsp_next.end_trigger = found_reg;
                rsp_next.note_out    = found_reg ? req_reg.note : '0;
            end
            OP_TICK:
            begin
                rsp_next.cleared_mask = mask_reg;
            end
            default:
            begin
                rsp_next.cleared_mask = '0;
            end
        endcase
    end

    // Effective count for a voice-count write and the voices it keeps
    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_eff = CW'(1);
        else if (cfg_wdata > mva_pkg::CFG_W'(MV))
            cfg_eff = CW'(MV);
        else
            cfg_eff = CW'(cfg_wdata);
        for (int v = 0; v < MV; v++)
        begin
            keep_mask[v] = CW'(v) < cfg_eff;
        end
    end

    // Sequencer, registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_NONE;
            req_reg        <= '0;
            scan_reg       <= '0;
            pass_reg       <= 1'b0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_stamp_reg <= '0;
            mask_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !fin_fire)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op_dec;
                        req_reg   <= req;
                        scan_reg  <= '0;
                        pass_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        mask_reg  <= '0;
                        state_reg <= (op_dec == OP_NONE) ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Restart the pointer for the steal pass, else advance it
                    if (steal_wrap)
                    begin
                        pass_reg <= 1'b1;
                        scan_reg <= '0;
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                    if (on_take)
                    begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= scan_reg;
                        best_stamp_reg <= stamp_rd;
                    end
                    if (tick_clr)
                        mask_reg[scan_reg] <= 1'b1;
                    if (off_hit)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= scan_reg;
                        state_reg    <= S_FINISH;
                    end
                    else if (scan_last && !steal_wrap)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (fin_fire)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Voice store, frame counter, active count and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            frame_reg  <= '0;
            count_reg  <= '0;
            listen_reg <= '0;
            voices_reg <= mva_pkg::CFG_W'(4);
            for (int v = 0; v < MV; v++)
            begin
                note_reg[v]  <= '0;
                stamp_reg[v] <= '0;
            end
        end
        else
        begin
            // Advance the frame counter as the tick is taken
            if (accept && op_dec == OP_TICK)
                frame_reg <= frame_reg + 1'b1;

            // Drop aged triggers during the tick scan
            if (tick_clr)
            begin
                start_reg[scan_reg] <= 1'b0;
                end_reg[scan_reg]   <= 1'b0;
            end

            // Commit the note-on or note-off to its voice
            if (fin_fire)
            begin
                count_reg <= count_next;
                if (op_reg == OP_ON)
                begin
                    active_reg[best_idx_reg] <= 1'b1;
                    start_reg[best_idx_reg]  <= 1'b1;
                    end_reg[best_idx_reg]    <= 1'b0;
                    note_reg[best_idx_reg]   <= req_reg.note;
                    stamp_reg[best_idx_reg]  <= frame_reg;
                end
                else if (op_reg == OP_OFF && found_reg)
                begin
                    active_reg[best_idx_reg] <= 1'b0;
                    start_reg[best_idx_reg]  <= 1'b0;
                    end_reg[best_idx_reg]    <= 1'b1;
                    note_reg[best_idx_reg]   <= '0;
                    stamp_reg[best_idx_reg]  <= frame_reg;
                end
            end

            // Configuration writes; a smaller voice count resets the voices dropped
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    mva_pkg::CFG_LISTEN_CHANNEL:
                    begin
                        listen_reg <= cfg_wdata[mva_pkg::CHAN_W-1:0];
                    end
                    mva_pkg::CFG_VOICES_IN_USE:
                    begin
                        voices_reg <= cfg_wdata;
                        count_reg  <= count_reg
                                      - mva_pkg::count_ones(active_reg & ~keep_mask);
                        active_reg <= active_reg & keep_mask;
                        start_reg  <= start_reg & keep_mask;
                        end_reg    <= end_reg & keep_mask;
                        for (int v = 0; v < MV; v++)
                        begin
                            if (!keep_mask[v])
                            begin
                                note_reg[v]  <= '0;
                                stamp_reg[v] <= '0;
                            end
                        end
                    end
                    default:
                    begin
                        listen_reg <= listen_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ----- hw/rtl/mva_checker.sv -----
module mva_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input mva_pkg::rsp_t rsp
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Take one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // Keep the count within the pool
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.active_voices <= mva_pkg::CNT_W'(mva_pkg::MAX_VOICES))
        else $error("active count beyond voice pool");

    // A tick never names a voice
    a_tick_no_voice: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.cleared_mask != '0 |-> !rsp.voice_valid && !rsp.start_trigger)
        else $error("cleared mask on a voice result");

    // A steal is always a note start
    a_steal_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stolen |-> rsp.voice_valid && rsp.start_trigger
                                     && !rsp.end_trigger)
        else $error("steal without a note start");

endmodule

bind midi_voice_allocator_unit mva_checker u_mva_checker (.*);

// ----- bench/midi_voice_allocator_unit_tb.sv -----
module midi_voice_allocator_unit_tb;

    import mva_pkg::*;

    // Request type with no meaning to the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 125;
    localparam int REPORT_LIMIT   = 10;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                cfg_we;
    logic                cfg_idx;
    logic [CFG_W-1:0]    cfg_wdata;

    // Voice pool predictor state
    logic [CHAN_W-1:0]     listen_chan;
    logic [CFG_W-1:0]      voices_cfg;
    bit                    voice_busy [MAX_VOICES];
    bit                    start_flag [MAX_VOICES];
    bit                    end_flag   [MAX_VOICES];
    logic [NOTE_W-1:0]     held_note  [MAX_VOICES];
    logic [STAMP_BITS-1:0] stamp_of   [MAX_VOICES];
    logic [STAMP_BITS-1:0] frame_no;
    logic [CNT_W-1:0]      busy_count;

    rsp_t pending_responses[$];
    int   mismatches;
    int   cycle_count;
    bit   sender_idles;
    bit   receiver_idles;

    midi_voice_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Voice pool predictor
    // ------------------------------------------------------------------

    function automatic int effective_voices();
        if (voices_cfg == 0)
            return 1;
        if (voices_cfg > MAX_VOICES)
            return MAX_VOICES;
        return int'(voices_cfg);
    endfunction

    function automatic void free_voice_slot(input int v);
        voice_busy[v] = 1'b0;
        start_flag[v] = 1'b0;
        end_flag[v]   = 1'b0;
        held_note[v]  = '0;
        stamp_of[v]   = '0;
    endfunction

    function automatic void reset_voice_pool();
        listen_chan = '0;
        voices_cfg  = 5'd4;
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            free_voice_slot(v);
        end
        frame_no   = '0;
        busy_count = '0;
    endfunction

    // Mirror a register write; shrinking the pool drops the upper voices
    function automatic void apply_register_write(input logic idx, input logic [CFG_W-1:0] data);
        int n;
        if (idx == CFG_LISTEN_CHANNEL)
        begin
            listen_chan = data[CHAN_W-1:0];
        end
        else
        begin
            voices_cfg = data;
            n = effective_voices();
            for (int v = n; v < MAX_VOICES; v++)
            begin
                if (voice_busy[v] && busy_count > 0)
                    busy_count--;
                free_voice_slot(v);
            end
        end
    endfunction

    // Work out the response to one request and advance the pool
    function automatic rsp_t allocate_or_release(input req_t item);
        rsp_t                  r;
        int                    n;
        int                    pick;
        bit                    found;
        logic [STAMP_BITS-1:0] age;
        r     = '0;
        n     = effective_voices();
        pick  = 0;
        found = 1'b0;
        if (item.req_type == REQ_NOTE_ON && item.channel == listen_chan)
        begin
            // take the idle voice with the lowest stamp, else steal the oldest
            for (int v = 0; v < n; v++)
            begin
                if (!voice_busy[v] && (!found || stamp_of[v] < stamp_of[pick]))
                begin
                    pick  = v;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                busy_count++;
            end
            else
            begin
                r.stolen = 1'b1;
                for (int v = 0; v < n; v++)
                begin
                    if (!found || stamp_of[v] < stamp_of[pick])
                    begin
                        pick  = v;
                        found = 1'b1;
                    end
                end
            end
            voice_busy[pick] = 1'b1;
            start_flag[pick] = 1'b1;
            end_flag[pick]   = 1'b0;
            held_note[pick]  = item.note;
            stamp_of[pick]   = frame_no;
            r.voice_valid    = 1'b1;
            r.voice_index    = VIDX_W'(pick);
            r.start_trigger  = 1'b1;
            r.note_out       = item.note;
            r.velocity_out   = item.velocity;
        end
        else if (item.req_type == REQ_NOTE_OFF && item.channel == listen_chan)
        begin
            // release the first sounding voice holding the note
            for (int v = 0; v < n; v++)
            begin
                if (voice_busy[v] && held_note[v] == item.note)
                begin
                    voice_busy[v] = 1'b0;
                    start_flag[v] = 1'b0;
                    end_flag[v]   = 1'b1;
                    held_note[v]  = '0;
                    stamp_of[v]   = frame_no;
                    if (busy_count > 0)
                        busy_count--;
                    r.voice_valid = 1'b1;
                    r.voice_index = VIDX_W'(v);
                    r.end_trigger = 1'b1;
                    r.note_out    = item.note;
                    break;
                end
            end
        end
        else if (item.req_type == REQ_TICK)
        begin
            // advance the frame and drop triggers more than one frame old
            frame_no = frame_no + 1'b1;
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                age = frame_no - stamp_of[v];
                if (age > 1 && (start_flag[v] || end_flag[v]))
                begin
                    start_flag[v]     = 1'b0;
                    end_flag[v]       = 1'b0;
                    r.cleared_mask[v] = 1'b1;
                end
            end
        end
        r.active_voices = busy_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side, register port and response checking
    // ------------------------------------------------------------------

    task automatic send_request(input req_t item);
        int   gap;
        rsp_t predicted;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        predicted = allocate_or_release(item);
        pending_responses.push_back(predicted);
    endtask

    task automatic issue(input logic [1:0] kind, input int chan, input int note, input int vel);
        req_t item;
        item.req_type = kind;
        item.channel  = CHAN_W'(chan);
        item.note     = NOTE_W'(note);
        item.velocity = NOTE_W'(vel);
        send_request(item);
    endtask

    // Hold off requests until every response is back
    task automatic wait_idle(input int extra);
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_responses.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        apply_register_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    function automatic void check_response(input rsp_t got);
        rsp_t want;
        if (pending_responses.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("response %h arrived with no request outstanding", got);
            return;
        end
        want = pending_responses.pop_front();
        compare_field("voice_valid",   16'(want.voice_valid),   16'(got.voice_valid));
        compare_field("voice_index",   16'(want.voice_index),   16'(got.voice_index));
        compare_field("stolen",        16'(want.stolen),        16'(got.stolen));
        compare_field("start_trigger", 16'(want.start_trigger), 16'(got.start_trigger));
        compare_field("end_trigger",   16'(want.end_trigger),   16'(got.end_trigger));
        compare_field("note_out",      16'(want.note_out),      16'(got.note_out));
        compare_field("velocity_out",  16'(want.velocity_out),  16'(got.velocity_out));
        compare_field("active_voices", 16'(want.active_voices), 16'(got.active_voices));
        compare_field("cleared_mask",  want.cleared_mask,       got.cleared_mask);
    endfunction

    // Take responses, with a random stall before each one while receiver_idles is set
    initial
    begin : response_side
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_idles ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            check_response(rsp);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("midi_voice_allocator_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill the default pool, steal, release and let triggers age out
    task automatic test_basic_allocation();
        issue(REQ_NOTE_ON,  0,   0, 127);
        issue(REQ_NOTE_ON,  0, 127,   0);
        issue(REQ_NOTE_ON,  0,  60,  64);
        issue(REQ_NOTE_ON,  0,  60,  65);
        issue(REQ_NOTE_ON,  0,  64, 100);
        issue(REQ_NOTE_OFF, 0,  60,  33);
        issue(REQ_NOTE_OFF, 0,  60,   0);
        issue(REQ_NOTE_OFF, 0,  99,   0);
        issue(REQ_NOTE_ON,  15, 42, 127);
        issue(REQ_NOTE_OFF, 15, 127, 0);
        issue(REQ_UNUSED,   15, 127, 127);
        issue(REQ_TICK,     0,   0,   0);
        issue(REQ_TICK,     15, 127, 127);
        issue(REQ_NOTE_ON,  0,  72,  90);
        wait_idle(SETTLE_CYCLES);
    endtask

    // Out-of-range voice counts, channel masking and a shrinking pool
    task automatic test_register_limits();
        write_register(CFG_VOICES_IN_USE, 5'd0);
        issue(REQ_NOTE_ON,  0,  5, 10);
        issue(REQ_NOTE_ON,  0,  6, 11);
        issue(REQ_NOTE_OFF, 0,  6,  0);
        wait_idle(SETTLE_CYCLES);
        write_register(CFG_LISTEN_CHANNEL, 5'h1F);
        issue(REQ_NOTE_ON,  15, 127, 127);
        issue(REQ_NOTE_ON,  0,  20,  20);
        wait_idle(SETTLE_CYCLES);
        write_register(CFG_VOICES_IN_USE, 5'd17);
        issue(REQ_NOTE_ON,  15, 30, 1);
        issue(REQ_NOTE_ON,  15, 31, 2);
        issue(REQ_NOTE_ON,  15, 32, 3);
        wait_idle(SETTLE_CYCLES);
        write_register(CFG_VOICES_IN_USE, 5'd1);
        issue(REQ_TICK,    15, 0, 0);
        issue(REQ_NOTE_ON, 15, 33, 4);
        wait_idle(SETTLE_CYCLES);
    endtask

    // Phases of mostly well-formed note traffic under varying settings
    task automatic test_random_traffic();
        int         voice_choice [6] = '{0, 1, 16, 31, 17, 2};
        int         on_weight;
        int         base_note;
        int         roll;
        int         done;
        req_t       item;
        logic [6:0] sounding_notes [$];
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle(SETTLE_CYCLES);
            sender_idles   = (phase % 4) != 3;
            receiver_idles = (phase % 4) != 3 && (phase % 4) != 1;
            if (phase == 0)
                write_register(CFG_LISTEN_CHANNEL, 5'h00);
            else if (phase == 1)
                write_register(CFG_LISTEN_CHANNEL, 5'h0F);
            else
                write_register(CFG_LISTEN_CHANNEL, CFG_W'($urandom_range(0, 31)));
            if (phase < 6)
                write_register(CFG_VOICES_IN_USE, CFG_W'(voice_choice[phase]));
            else
                write_register(CFG_VOICES_IN_USE, CFG_W'($urandom_range(0, 31)));
            on_weight = $urandom_range(25, 50);
            base_note = $urandom_range(0, 120);
            done      = 0;
            while (done < PHASE_REQUESTS)
            begin
                item.channel  = listen_chan;
                item.velocity = NOTE_W'($urandom_range(0, 127));
                if ($urandom_range(0, 3) == 0)
                    item.note = NOTE_W'($urandom_range(0, 127));
                else
                    item.note = NOTE_W'(base_note + $urandom_range(0, 7));
                roll = $urandom_range(0, 99);
                if (roll < on_weight)
                begin
                    item.req_type = REQ_NOTE_ON;
                end
                else if (roll < on_weight + 25)
                begin
                    // release a note that is sounding, most of the time
                    item.req_type = REQ_NOTE_OFF;
                    sounding_notes.delete();
                    for (int v = 0; v < effective_voices(); v++)
                    begin
                        if (voice_busy[v])
                            sounding_notes.push_back(held_note[v]);
                    end
                    if (sounding_notes.size() != 0 && $urandom_range(0, 4) != 0)
                        item.note = sounding_notes[$urandom_range(0, sounding_notes.size() - 1)];
                end
                else if (roll < on_weight + 40)
                begin
                    item.req_type = REQ_TICK;
                    item.channel  = CHAN_W'($urandom_range(0, 15));
                end
                else
                begin
                    // noise: foreign channel, unused code or stray release
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            item.req_type = REQ_NOTE_ON;
                            item.channel  = listen_chan ^ CHAN_W'($urandom_range(1, 15));
                        end
                        1:
                        begin
                            item.req_type = REQ_NOTE_OFF;
                            item.channel  = listen_chan ^ CHAN_W'($urandom_range(1, 15));
                        end
                        2:
                        begin
                            item.req_type = REQ_UNUSED;
                            item.channel  = CHAN_W'($urandom_range(0, 15));
                        end
                        default:
                        begin
                            item.req_type = REQ_NOTE_OFF;
                            item.note     = NOTE_W'($urandom_range(0, 127));
                        end
                    endcase
                end
                send_request(item);
                done++;
                if ($urandom_range(0, 63) == 0)
                    wait_idle(0);
            end
        end
        wait_idle(SETTLE_CYCLES);
    endtask

    initial
    begin : main_sequence
        req_valid  <= 1'b0;
        req        <= '0;
        cfg_we     <= 1'b0;
        cfg_idx    <= CFG_LISTEN_CHANNEL;
        cfg_wdata  <= '0;
        rst_n      <= 1'b0;
        mismatches     = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        reset_voice_pool();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_allocation();
        test_register_limits();
        test_random_traffic();

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("midi_voice_allocator_unit verification clean");
        else
            $display("midi_voice_allocator_unit verification failed");
        $finish;
    end

endmodule
